// ===== sv/iss_pkg.sv =====
package iss_pkg;

   localparam int MAX_BITS_DEF    = 32;
   localparam int DELAY_WIDTH_DEF = 16;
   localparam int IDX_W           = 7;

   typedef enum logic [1:0] {
      CMD_IDLE       = 2'd0,
      CMD_SHIFT_OUT  = 2'd1,
      CMD_SHIFT_IN   = 2'd2,
      CMD_FOUR_PHASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEQ_OUT       = 2'd0,
      SEQ_IN_AFTER  = 2'd1,
      SEQ_IN_BEFORE = 2'd2,
      SEQ_FOUR      = 2'd3
   } seq_type;

   // H: clock high, HD: high + data bit, HT: high + TMS bit,
   // L: clock low, S: sample, SP: pull level + discarded sample
   typedef enum logic [2:0] {
      SEG_H  = 3'd0,
      SEG_HD = 3'd1,
      SEG_HT = 3'd2,
      SEG_L  = 3'd3,
      SEG_S  = 3'd4,
      SEG_SP = 3'd5
   } seg_type;

   typedef enum logic [2:0] {
      REG_HIGH_TICKS   = 3'd0,
      REG_LOW_TICKS    = 3'd1,
      REG_MSB_LEAD     = 3'd2,
      REG_SAMPLE_FIRST = 3'd3,
      REG_PIN_RULES    = 3'd4
   } reg_type;

   localparam int PR_DOUT_INV = 0;
   localparam int PR_CLK_INV  = 1;
   localparam int PR_DIN_INV  = 2;
   localparam int PR_PULLUP   = 3;
   localparam int PR_PULLDOWN = 4;

   typedef struct packed {
      logic [15:0] high_ticks;
      logic [15:0] low_ticks;
      logic        msb_lead;
      logic        sample_before_clock;
      logic [4:0]  pin_rules;
   } cfg_type;

   function automatic logic [3:0] seq_len(input seq_type sel);
      logic [3:0] len;
      unique case (sel)
         SEQ_OUT:       len = 4'd2;
         SEQ_IN_AFTER:  len = 4'd3;
         SEQ_IN_BEFORE: len = 4'd3;
         SEQ_FOUR:      len = 4'd10;
         default:       len = 4'd2;
      endcase
      return len;
   endfunction

   function automatic seg_type seg_code(input seq_type sel, input logic [3:0] step);
      seg_type seg;
      seg = SEG_L;
      unique case (sel)
         SEQ_OUT:       seg = (step == 4'd0) ? SEG_HD : SEG_L;
         SEQ_IN_AFTER: begin
            unique case (step)
               4'd0:    seg = SEG_H;
               4'd1:    seg = SEG_L;
               default: seg = SEG_S;
            endcase
         end
         SEQ_IN_BEFORE: begin
            unique case (step)
               4'd0:    seg = SEG_S;
               4'd1:    seg = SEG_H;
               default: seg = SEG_L;
            endcase
         end
         default: begin
            unique case (step)
               4'd0:    seg = SEG_HD;
               4'd1:    seg = SEG_L;
               4'd2:    seg = SEG_HT;
               4'd3:    seg = SEG_L;
               4'd4:    seg = SEG_SP;
               4'd5:    seg = SEG_H;
               4'd6:    seg = SEG_L;
               4'd7:    seg = SEG_S;
               4'd8:    seg = SEG_H;
               default: seg = SEG_L;
            endcase
         end
      endcase
      return seg;
   endfunction

endpackage

// ===== sv/iss_engine.sv =====
module iss_engine #(
   parameter int MAX_BITS    = iss_pkg::MAX_BITS_DEF,
   parameter int DELAY_WIDTH = iss_pkg::DELAY_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  iss_pkg::cfg_type cfg,
   input  logic [1:0]       func,
   input  logic [5:0]       bit_count,
   input  logic [31:0]      out_word,
   input  logic [31:0]      tms_word,
   input  logic             data_pin_in,
   output logic             clock_pin,
   output logic             data_pin_out,
   output logic             busy_res,
   output logic             done_res,
   output logic [31:0]      read_word
);
   import iss_pkg::*;

   localparam int CW = $clog2(MAX_BITS + 1);
   localparam int DW = DELAY_WIDTH;

   cmd_type       kind_ff, kind_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [3:0]    step_ff, step_in;
   logic [DW-1:0] dly_ff, dly_in;
   logic [31:0]   snd_ff, snd_in;
   logic [31:0]   mode_ff, mode_in;
   logic [31:0]   cap_ff, cap_in;
   logic          clk_ff, clk_in;
   logic          dat_ff, dat_in;
   seq_type       sel_ff, sel_in;
   logic          omsb_ff, omsb_in;

   function automatic logic [DW-1:0] eff_delay(input logic [15:0] v);
      logic [DW-1:0] d;
      d = DW'(v);
      return (d == '0) ? DW'(1) : d;
   endfunction

   always_comb begin
      cmd_type        fc;
      logic [6:0]     n_x;
      logic [CW-1:0]  n;
      logic [CW-1:0]  tot;
      logic [CW-1:0]  idx;
      logic [IDX_W-1:0] idx_x;
      logic           in_range;
      seg_type        seg;

      kind_in  = kind_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      dly_in   = dly_ff;
      snd_in   = snd_ff;
      mode_in  = mode_ff;
      cap_in   = cap_ff;
      clk_in   = clk_ff;
      dat_in   = dat_ff;
      sel_in   = sel_ff;
      omsb_in  = omsb_ff;
      busy_res = 1'b0;
      done_res = 1'b0;
      read_word = '0;

      fc  = cmd_type'(func);
      n_x = {1'b0, bit_count};
      if (n_x > IDX_W'(MAX_BITS)) begin
         n_x = IDX_W'(MAX_BITS);
      end
      n = CW'(n_x);

      if (kind_ff == CMD_IDLE && fc != CMD_IDLE) begin
         snd_in  = out_word;
         mode_in = tms_word;
         cap_in  = '0;
         omsb_in = cfg.msb_lead;
         unique case (fc)
            CMD_SHIFT_OUT: sel_in = SEQ_OUT;
            CMD_SHIFT_IN:  sel_in = cfg.sample_before_clock ? SEQ_IN_BEFORE : SEQ_IN_AFTER;
            default:       sel_in = SEQ_FOUR;
         endcase
         if (fc == CMD_SHIFT_IN) begin
            if (cfg.pin_rules[PR_PULLUP]) begin
               dat_in = 1'b1;
            end else if (cfg.pin_rules[PR_PULLDOWN]) begin
               dat_in = 1'b0;
            end
         end
         if (n == '0) begin
            busy_res = 1'b1;
            done_res = 1'b1;
         end else begin
            kind_in = fc;
            left_in = n;
            pos_in  = '0;
            step_in = '0;
            dly_in  = '0;
         end
      end

      tot = left_in + pos_in;
      if (kind_in == CMD_FOUR_PHASE || !omsb_in) begin
         idx = pos_in;
      end else begin
         idx = tot - CW'(1) - pos_in;
      end
      idx_x    = IDX_W'(idx);
      in_range = (idx_x < IDX_W'(32));
      seg      = seg_code(sel_in, step_in);

      if (kind_in != CMD_IDLE) begin
         busy_res = 1'b1;
         if (dly_in == '0) begin
            clk_in = (seg == SEG_H || seg == SEG_HD || seg == SEG_HT);
            if (seg == SEG_HD) begin
               dat_in = in_range ? snd_in[idx_x[4:0]] : 1'b0;
            end else if (seg == SEG_HT) begin
               dat_in = in_range ? mode_in[idx_x[4:0]] : 1'b0;
            end else if (seg == SEG_SP) begin
               if (cfg.pin_rules[PR_PULLUP]) begin
                  dat_in = 1'b1;
               end else if (cfg.pin_rules[PR_PULLDOWN]) begin
                  dat_in = 1'b0;
               end
            end
            if (seg == SEG_S && in_range &&
                (data_pin_in ^ cfg.pin_rules[PR_DIN_INV])) begin
               cap_in[idx_x[4:0]] = 1'b1;
            end
            if (seg == SEG_L) begin
               dly_in = eff_delay(cfg.low_ticks);
            end else if (seg == SEG_S || seg == SEG_SP) begin
               dly_in = DW'(1);
            end else begin
               dly_in = eff_delay(cfg.high_ticks);
            end
         end
         dly_in = dly_in - DW'(1);
         if (dly_in == '0) begin
            step_in = step_in + 4'd1;
            if (step_in >= seq_len(sel_in)) begin
               step_in = '0;
               pos_in  = pos_in + CW'(1);
               left_in = left_in - CW'(1);
               if (left_in == '0) begin
                  done_res  = 1'b1;
                  read_word = cap_in;
                  kind_in   = CMD_IDLE;
               end
            end
         end
      end

      clock_pin    = clk_in ^ cfg.pin_rules[PR_CLK_INV];
      data_pin_out = dat_in ^ cfg.pin_rules[PR_DOUT_INV];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CMD_IDLE;
         left_ff <= '0;
         pos_ff  <= '0;
         step_ff <= '0;
         dly_ff  <= '0;
         snd_ff  <= '0;
         mode_ff <= '0;
         cap_ff  <= '0;
         clk_ff  <= 1'b0;
         dat_ff  <= 1'b0;
         sel_ff  <= SEQ_OUT;
         omsb_ff <= 1'b0;
      end else if (step_en) begin
         kind_ff <= kind_in;
         left_ff <= left_in;
         pos_ff  <= pos_in;
         step_ff <= step_in;
         dly_ff  <= dly_in;
         snd_ff  <= snd_in;
         mode_ff <= mode_in;
         cap_ff  <= cap_in;
         clk_ff  <= clk_in;
         dat_ff  <= dat_in;
         sel_ff  <= sel_in;
         omsb_ff <= omsb_in;
      end
   end

endmodule

// ===== sv/icsp_serial_shift_engine.sv =====
// A response is valid in the cycle after its request transaction is accepted.
// Throughput: one tick transaction per cycle unless a held response stalls; the tick
// sequencer updates in a single pass between request handshake and response register.
// Reset (synchronous, active high) idles the sequencer, clears pin levels and
// restores the register defaults (high/low ticks 1, LSB first, sample after, rules 15).
module icsp_serial_shift_engine #(
   parameter int MAX_BITS    = iss_pkg::MAX_BITS_DEF,
   parameter int DELAY_WIDTH = iss_pkg::DELAY_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_bit_count,
   input  logic [31:0] req_out_word,
   input  logic [31:0] req_tms_word,
   input  logic        req_data_pin_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_clock_pin,
   output logic        rsp_data_pin_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [31:0] rsp_read_word,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import iss_pkg::*;

   cfg_type     cfg_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        nx_clock_pin, nx_data_pin_out, nx_busy, nx_done;
   logic [31:0] nx_read_word;
   logic        clock_pin_ff, data_pin_out_ff, busy_ff, done_ff;
   logic [31:0] read_word_ff;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   iss_engine #(
      .MAX_BITS    (MAX_BITS),
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .cfg          (cfg_ff),
      .func         (req_func),
      .bit_count    (req_bit_count),
      .out_word     (req_out_word),
      .tms_word     (req_tms_word),
      .data_pin_in  (req_data_pin_in),
      .clock_pin    (nx_clock_pin),
      .data_pin_out (nx_data_pin_out),
      .busy_res     (nx_busy),
      .done_res     (nx_done),
      .read_word    (nx_read_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_ticks          <= 16'd1;
         cfg_ff.low_ticks           <= 16'd1;
         cfg_ff.msb_lead            <= 1'b0;
         cfg_ff.sample_before_clock <= 1'b0;
         cfg_ff.pin_rules           <= 5'd15;
      end else if (csr_we) begin
         unique case (reg_type'(csr_addr))
            REG_HIGH_TICKS:   cfg_ff.high_ticks          <= csr_wdata;
            REG_LOW_TICKS:    cfg_ff.low_ticks           <= csr_wdata;
            REG_MSB_LEAD:     cfg_ff.msb_lead            <= csr_wdata[0];
            REG_SAMPLE_FIRST: cfg_ff.sample_before_clock <= csr_wdata[0];
            REG_PIN_RULES:    cfg_ff.pin_rules           <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         clock_pin_ff    <= nx_clock_pin;
         data_pin_out_ff <= nx_data_pin_out;
         busy_ff         <= nx_busy;
         done_ff         <= nx_done;
         read_word_ff    <= nx_read_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clock_pin    = clock_pin_ff;
   assign rsp_data_pin_out = data_pin_out_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_word    = read_word_ff;

endmodule
